// File: design/ntfs_data_run_decoder_unit_macros.svh
// -----------------------------------------------------------------------------
// NTFS data-run decoder assertion macros
// Short forms for clocked, reset-qualified concurrent assertions.
// -----------------------------------------------------------------------------
`ifndef NTFS_DATA_RUN_DECODER_UNIT_MACROS_SVH
`define NTFS_DATA_RUN_DECODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NDR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NDR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ndr_pkg.sv
// -----------------------------------------------------------------------------
// NTFS data-run decoder package
// Shared types, state codes and register indexes of the data-run decoder.
// -----------------------------------------------------------------------------
`default_nettype none

package ndr_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_CLUSTER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_START_SECTOR = 1'b1;

    localparam logic [7:0] SPC_RESET = 8'd8;

    // Largest legal size nibble in a run header.
    localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_LENGTH = 3'b010,
        PH_OFFSET = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] run_byte;
        logic       attr_end;
    } run_item_t;

    typedef struct packed {
        logic        run_valid;
        logic [63:0] start_sector;
        logic [63:0] sector_count;
        logic        is_sparse;
        logic        list_end;
        logic        malformed;
    } run_result_t;

    // A decoded run still in cluster units, waiting for the sector scaling.
    typedef struct packed {
        logic        run_valid;
        logic [63:0] cluster_count;
        logic [63:0] start_cluster;
        logic        is_sparse;
        logic        list_end;
        logic        malformed;
    } run_job_t;

endpackage

`default_nettype wire

// File: design/ntfs_data_run_decoder_unit.sv
// -----------------------------------------------------------------------------
// NTFS data-run decoder
// Decodes an NTFS mapping-pairs list, one byte per transfer, into sector runs.
// -----------------------------------------------------------------------------
// Usage. The byte channel (byte_valid, byte_stall, byte_data) carries one byte
// of the run list per transfer, with attr_end set on the last byte that the
// attribute holds. A transfer happens when valid is high and stall is low.
// The result channel (result_valid, result_stall, result_data) carries one
// transfer for each completed run and one for each end of the list (zero
// header, attribute end or malformed size nibble); other bytes give none.
// Throughput is one byte per clock cycle while byte_stall is low. The edge that
// takes a byte updates the run state and captures a completed run, in cluster
// units, into the capture stage; from there it is scaled by sectors_per_cluster
// (two 64 by 8 bit multipliers), the volume start is added and the result is
// registered in the output register. When the receiver stalls, the output
// register and the capture stage fill up and byte_stall rises only once both
// hold a result, so bytes that cause no result still flow past a full output.
// Reset (rst_n low, asynchronous) empties both stages, returns the decoder to
// waiting for a header byte with the running cluster at zero, and sets
// sectors_per_cluster to 8 and volume_start_sector to 0. Configuration is
// written through cfg_we, cfg_index and cfg_data; the user must write it only
// while no result is in flight, which the block itself does not enforce.
// -----------------------------------------------------------------------------
`default_nettype none

`include "ntfs_data_run_decoder_unit_macros.svh"

module ntfs_data_run_decoder_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            byte_valid,
    output logic                                 byte_stall,
    input  wire ndr_pkg::run_item_t              byte_data,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output ndr_pkg::run_result_t                 result_data,
    input  wire logic                            cfg_we,
    input  wire logic [ndr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [63:0]                     cfg_data
);

    // Configuration registers.
    logic [7:0]  spc_reg;
    logic [63:0] vol_start_reg;

    // Run-list decode state.
    ndr_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [3:0]  off_total_reg, off_total_next;
    logic [3:0]  byte_pos_reg, byte_pos_next;
    logic [63:0] count_acc_reg, count_acc_next;
    logic [63:0] off_acc_reg, off_acc_next;
    logic [63:0] run_cluster_reg, run_cluster_next;

    // Capture stage and output register.
    logic              job_valid_reg;
    ndr_pkg::run_job_t job_reg, job_next;
    logic              result_valid_reg;
    ndr_pkg::run_result_t result_reg, result_next;

    // Handshake.
    logic out_free;
    logic job_free;
    logic accept;
    logic emit;
    logic clear_run;
    logic clear_all;

    // Per-byte datapath terms.
    logic [7:0]  run_byte;
    logic        last;
    logic [3:0]  len_nib;
    logic [3:0]  off_nib;
    logic [63:0] byte_shifted;
    logic [3:0]  pos_inc;
    logic [3:0]  len_dec;
    logic [63:0] count_or;
    logic [63:0] off_or;
    logic [5:0]  sign_idx;
    logic [63:0] off_ext;
    logic [63:0] cluster_sum;

    // Scaling products, modulo two to the 64.
    logic [63:0] start_prod;
    logic [63:0] count_prod;

    // -------------------------------------------------------------------------
    // Handshake: the capture stage may take a new result whenever it is empty
    // or is being emptied into the output register in the same cycle.
    // -------------------------------------------------------------------------
    assign out_free   = !result_valid_reg || !result_stall;
    assign job_free   = !job_valid_reg || out_free;
    assign byte_stall = !job_free;
    assign accept     = byte_valid && job_free;

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // -------------------------------------------------------------------------
    // Configuration writes.
    // -------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg       <= ndr_pkg::SPC_RESET;
            vol_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ndr_pkg::CFG_SECTORS_PER_CLUSTER: spc_reg       <= cfg_data[7:0];
                ndr_pkg::CFG_VOLUME_START_SECTOR: vol_start_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------------------------
    // Byte decode. Each byte is either a header, one byte of the little-endian
    // cluster count, or one byte of the signed cluster delta.
    // -------------------------------------------------------------------------
    assign run_byte     = byte_data.run_byte;
    assign last         = byte_data.attr_end;
    assign len_nib      = run_byte[3:0];
    assign off_nib      = run_byte[7:4];
    assign byte_shifted = {56'd0, run_byte} << {byte_pos_reg[2:0], 3'b000};
    assign pos_inc      = byte_pos_reg + 4'd1;
    assign len_dec      = len_left_reg - 4'd1;
    assign count_or     = count_acc_reg | byte_shifted;
    assign off_or       = off_acc_reg | byte_shifted;

    // The delta is sign-extended from the top bit of its last byte, unless it
    // already fills all eight bytes.
    assign sign_idx = {off_total_reg[2:0], 3'b000} - 6'd1;

    always_comb
    begin
        off_ext = off_or;
        if (!off_total_reg[3] && off_or[sign_idx])
        begin
            off_ext = off_or | ({64{1'b1}} << {off_total_reg[2:0], 3'b000});
        end
    end

    assign cluster_sum = run_cluster_reg + off_ext;

    always_comb
    begin
        phase_next       = phase_reg;
        len_left_next    = len_left_reg;
        off_total_next   = off_total_reg;
        byte_pos_next    = byte_pos_reg;
        count_acc_next   = count_acc_reg;
        off_acc_next     = off_acc_reg;
        run_cluster_next = run_cluster_reg;
        job_next         = '0;
        emit             = 1'b0;
        clear_run        = 1'b0;
        clear_all        = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                ndr_pkg::PH_LENGTH:
                begin
                    count_acc_next = count_or;
                    byte_pos_next  = pos_inc;
                    len_left_next  = len_dec;
                    if (len_dec == 4'd0)
                    begin
                        if (off_total_reg == 4'd0)
                        begin
                            // No delta field: the run is sparse.
                            emit                   = 1'b1;
                            job_next.run_valid     = 1'b1;
                            job_next.cluster_count = count_or;
                            job_next.is_sparse     = 1'b1;
                            job_next.list_end      = last;
                            clear_run              = 1'b1;
                            clear_all              = last;
                        end
                        else
                        begin
                            phase_next    = ndr_pkg::PH_OFFSET;
                            byte_pos_next = 4'd0;
                            if (last)
                            begin
                                emit              = 1'b1;
                                job_next.list_end = 1'b1;
                                clear_all         = 1'b1;
                            end
                        end
                    end
                    else if (last)
                    begin
                        emit              = 1'b1;
                        job_next.list_end = 1'b1;
                        clear_all         = 1'b1;
                    end
                end

                ndr_pkg::PH_OFFSET:
                begin
                    off_acc_next  = off_or;
                    byte_pos_next = pos_inc;
                    if (pos_inc >= off_total_reg)
                    begin
                        run_cluster_next       = cluster_sum;
                        emit                   = 1'b1;
                        job_next.run_valid     = 1'b1;
                        job_next.cluster_count = count_acc_reg;
                        job_next.start_cluster = cluster_sum;
                        job_next.list_end      = last;
                        clear_run              = 1'b1;
                        clear_all              = last;
                    end
                    else if (last)
                    begin
                        emit              = 1'b1;
                        job_next.list_end = 1'b1;
                        clear_all         = 1'b1;
                    end
                end

                default:
                begin
                    // Header byte; an unknown phase code also lands here.
                    if (run_byte == 8'h00)
                    begin
                        emit              = 1'b1;
                        job_next.list_end = 1'b1;
                        clear_all         = 1'b1;
                    end
                    else if (len_nib > ndr_pkg::MAX_FIELD_BYTES
                             || off_nib > ndr_pkg::MAX_FIELD_BYTES)
                    begin
                        emit               = 1'b1;
                        job_next.list_end  = 1'b1;
                        job_next.malformed = 1'b1;
                        clear_all          = 1'b1;
                    end
                    else if (last)
                    begin
                        emit              = 1'b1;
                        job_next.list_end = 1'b1;
                        clear_all         = 1'b1;
                    end
                    else
                    begin
                        len_left_next  = len_nib;
                        off_total_next = off_nib;
                        byte_pos_next  = 4'd0;
                        count_acc_next = '0;
                        off_acc_next   = '0;
                        phase_next     = (len_nib != 4'd0) ? ndr_pkg::PH_LENGTH
                                                           : ndr_pkg::PH_OFFSET;
                    end
                end
            endcase
        end

        // Finishing a run clears the per-run fields; ending the list also
        // drops the running cluster number.
        if (clear_run || clear_all)
        begin
            phase_next     = ndr_pkg::PH_HEADER;
            len_left_next  = 4'd0;
            off_total_next = 4'd0;
            byte_pos_next  = 4'd0;
            count_acc_next = '0;
            off_acc_next   = '0;
        end
        if (clear_all)
        begin
            run_cluster_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ndr_pkg::PH_HEADER;
            len_left_reg    <= '0;
            off_total_reg   <= '0;
            byte_pos_reg    <= '0;
            count_acc_reg   <= '0;
            off_acc_reg     <= '0;
            run_cluster_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            len_left_reg    <= len_left_next;
            off_total_reg   <= off_total_next;
            byte_pos_reg    <= byte_pos_next;
            count_acc_reg   <= count_acc_next;
            off_acc_reg     <= off_acc_next;
            run_cluster_reg <= run_cluster_next;
        end
    end

    // -------------------------------------------------------------------------
    // Capture stage.
    // -------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (job_free)
        begin
            job_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            job_reg <= job_next;
        end
    end

    // -------------------------------------------------------------------------
    // Sector scaling into the output register.
    // -------------------------------------------------------------------------
    assign start_prod = job_reg.start_cluster * {56'd0, spc_reg};
    assign count_prod = job_reg.cluster_count * {56'd0, spc_reg};

    always_comb
    begin
        result_next.run_valid    = job_reg.run_valid;
        result_next.start_sector = (job_reg.run_valid && !job_reg.is_sparse)
                                   ? vol_start_reg + start_prod : 64'd0;
        result_next.sector_count = count_prod;
        result_next.is_sparse    = job_reg.is_sparse;
        result_next.list_end     = job_reg.list_end;
        result_next.malformed    = job_reg.malformed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= job_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && job_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // -------------------------------------------------------------------------
    // Assertions.
    // -------------------------------------------------------------------------
    `NDR_ASSERT_IMP(a_malformed_ends_list,
        result_valid && result_data.malformed,
        result_data.list_end && !result_data.run_valid,
        "malformed result without list end or with a run")
    `NDR_ASSERT_IMP(a_sparse_has_no_start,
        result_valid && result_data.is_sparse,
        result_data.run_valid && result_data.start_sector == 64'd0,
        "sparse result with a start sector")
    `NDR_ASSERT_NXT(a_job_held_on_stall,
        job_valid_reg && !out_free,
        job_valid_reg && $stable(job_reg),
        "captured run lost while the output stalls")
    `NDR_ASSERT_NXT(a_list_end_clears,
        accept && emit && job_next.list_end,
        phase_reg == ndr_pkg::PH_HEADER && run_cluster_reg == 64'd0,
        "list end did not clear the decoder")

endmodule

`default_nettype wire
